>>> design/vfvc_pkg.sv
// Shared types and constants for the voxel face visibility cull block.
// Holds command, class and register index codes, the sequencer state type
// and the default chunk dimensions. No dependencies.
`default_nettype none

package vfvc_pkg;

  localparam int DEF_MAX_X      = 16;
  localparam int DEF_MAX_Y      = 16;
  localparam int DEF_MAX_Z      = 16;
  localparam int DEF_TYPE_COUNT = 16;

  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD_CELL = 2'd0;
  localparam cmd_t CMD_LOAD_FACE = 2'd1;
  localparam cmd_t CMD_EVAL      = 2'd2;

  typedef logic [1:0] region_t;
  localparam region_t REG_BACK  = 2'd0;
  localparam region_t REG_FRONT = 2'd1;
  localparam region_t REG_LEFT  = 2'd2;
  localparam region_t REG_RIGHT = 2'd3;

  typedef logic [2:0] class_t;
  localparam class_t CLS_EMPTY   = 3'd0;
  localparam class_t CLS_CULLED  = 3'd1;
  localparam class_t CLS_INST    = 3'd2;
  localparam class_t CLS_SPAWN   = 3'd3;
  localparam class_t CLS_SPAWNED = 3'd4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SIZE_X     = 3'd0;
  localparam cfg_idx_t CFG_SIZE_Y     = 3'd1;
  localparam cfg_idx_t CFG_SIZE_Z     = 3'd2;
  localparam cfg_idx_t CFG_ACTOR_MASK = 3'd3;
  localparam cfg_idx_t CFG_NB_PRESENT = 3'd4;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_CELL,
    SRC_FACE
  } src_t;

endpackage

`default_nettype wire

>>> design/voxel_face_visibility_cull.sv
// Top level of the voxel face visibility cull block: chunk cell store,
// neighbor face store and the lookup sequencer that classifies one cell.
// Depends on vfvc_pkg.
`default_nettype none

// After reset the block sweeps both stores to empty, one entry per cycle,
// with s_tready low; configuration writes are taken throughout.
// A load or an unknown command is taken in idle, and s_tready stays high.
// An evaluate holds s_tready low from its transfer until the block is idle
// again: the center cell and its six neighbors are read one per cycle
// through the single port of the cell or face store, then the finish state
// classifies the cell, writes back the spawned flag and loads the output
// register; it stays in that state while a result still waits in the
// output register. A result waiting in the output register does not block
// the next input transfer, only the next classification.
module voxel_face_visibility_cull #(
  parameter int MAX_X      = vfvc_pkg::DEF_MAX_X,
  parameter int MAX_Y      = vfvc_pkg::DEF_MAX_Y,
  parameter int MAX_Z      = vfvc_pkg::DEF_MAX_Z,
  parameter int TYPE_COUNT = vfvc_pkg::DEF_TYPE_COUNT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // region, x, y, z, block_type, actor_spawned (lowest bits first)
  input  wire logic [vfvc_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd
  input  wire logic [vfvc_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // cell_type, out_x, out_y, out_z (lowest bits first)
  output logic [vfvc_pkg::M_TDATA_W-1:0]      m_tdata,
  // cell_class
  output logic [vfvc_pkg::M_TUSER_W-1:0]      m_tuser,
  input  wire logic                           cfg_we,
  input  wire logic [vfvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vfvc_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam int FACE_W      = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
  localparam int CELL_DEPTH  = MAX_X * MAX_Y * MAX_Z;
  localparam int FACE_REGION = FACE_W * MAX_Z;
  localparam int FACE_DEPTH  = 4 * FACE_REGION;
  localparam int CLR_DEPTH   = (CELL_DEPTH > FACE_DEPTH) ? CELL_DEPTH : FACE_DEPTH;
  localparam int CELL_AW     = $clog2(CELL_DEPTH);
  localparam int FACE_AW     = $clog2(FACE_DEPTH);
  localparam int CLR_W       = $clog2(CLR_DEPTH);

  // configuration
  logic [4:0]  size_x, size_y, size_z;
  logic [15:0] actor_mask;
  logic [3:0]  nb_present;

  // stores
  logic [4:0]         cell_mem [CELL_DEPTH];
  logic [3:0]         face_mem [FACE_DEPTH];
  logic [CELL_AW-1:0] cell_addr;
  logic [FACE_AW-1:0] face_addr;
  logic               cell_we, face_we;
  logic [4:0]         cell_wdata, cell_rdata;
  logic [3:0]         face_wdata, face_rdata;

  // sequencer
  vfvc_pkg::state_t state, state_next;
  logic [CLR_W-1:0] clr_cnt;
  logic [2:0]       step;
  vfvc_pkg::src_t   pend_src;
  logic [3:0]       ev_x, ev_y, ev_z;
  logic             ev_inside;
  logic [4:0]       center;
  logic             vis;

  // input fields
  vfvc_pkg::cmd_t    in_cmd;
  vfvc_pkg::region_t in_region;
  logic [3:0]        in_x, in_y, in_z, in_type;
  logic              in_spawned;
  logic              s_xfer;
  logic [4:0]        sx, sy, sz;
  logic              in_inside, face_ok;
  logic [4:0]        in_fc;

  // neighbor lookup
  logic signed [5:0] dx, dy, dz, nx, ny, nz;
  logic              x_neg, x_hi, y_neg, y_hi, z_in;
  vfvc_pkg::region_t nb_region;
  logic [4:0]        nb_fc;
  vfvc_pkg::src_t    nb_src;
  logic [CELL_AW-1:0] nb_cell_addr;
  logic [FACE_AW-1:0] nb_face_addr;
  logic [3:0]        nb_data;

  // classification
  logic                 out_room;
  logic                 vis_final;
  logic [3:0]           ctype;
  vfvc_pkg::class_t     cls;
  logic                 spawn;

  function automatic logic [4:0] clamp_size(input logic [4:0] v, input int maxv);
    logic [4:0] r;
    if (v == 5'd0) begin
      r = 5'd1;
    end else if (32'(v) > maxv) begin
      r = 5'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CELL_AW-1:0] cell_index(input logic [4:0] cx,
                                                    input logic [4:0] cy,
                                                    input logic [4:0] cz);
    logic [31:0] a;
    a = 32'(cx) + 32'(MAX_X) * (32'(cy) + 32'(MAX_Y) * 32'(cz));
    return a[CELL_AW-1:0];
  endfunction

  function automatic logic [FACE_AW-1:0] face_index(input logic [1:0] r,
                                                    input logic [4:0] fc,
                                                    input logic [4:0] fz);
    logic [31:0] a;
    a = 32'(r) * 32'(FACE_REGION) + 32'(fc) + 32'(FACE_W) * 32'(fz);
    return a[FACE_AW-1:0];
  endfunction

  function automatic logic is_actor(input logic [3:0] t, input logic [15:0] mask);
    return (32'(t) < TYPE_COUNT) && mask[t];
  endfunction

  assign in_region  = vfvc_pkg::region_t'(s_tdata[1:0]);
  assign in_x       = s_tdata[5:2];
  assign in_y       = s_tdata[9:6];
  assign in_z       = s_tdata[13:10];
  assign in_type    = s_tdata[17:14];
  assign in_spawned = s_tdata[18];
  assign in_cmd     = vfvc_pkg::cmd_t'(s_tuser);
  assign s_xfer     = s_tvalid && s_tready;

  assign sx = clamp_size(size_x, MAX_X);
  assign sy = clamp_size(size_y, MAX_Y);
  assign sz = clamp_size(size_z, MAX_Z);

  assign in_inside = ({1'b0, in_x} < sx) && ({1'b0, in_y} < sy) && ({1'b0, in_z} < sz);
  assign in_fc     = (in_region == vfvc_pkg::REG_BACK || in_region == vfvc_pkg::REG_FRONT)
                     ? {1'b0, in_y} : {1'b0, in_x};
  assign face_ok   = (in_region == vfvc_pkg::REG_BACK || in_region == vfvc_pkg::REG_FRONT)
                     ? (in_fc < sy) && ({1'b0, in_z} < sz)
                     : (in_fc < sx) && ({1'b0, in_z} < sz);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= 5'd16;
      size_y     <= 5'd16;
      size_z     <= 5'd16;
      actor_mask <= '0;
      nb_present <= '0;
    end else if (cfg_we) begin
      case (vfvc_pkg::cfg_idx_t'(cfg_index))
        vfvc_pkg::CFG_SIZE_X:     size_x     <= cfg_wdata[4:0];
        vfvc_pkg::CFG_SIZE_Y:     size_y     <= cfg_wdata[4:0];
        vfvc_pkg::CFG_SIZE_Z:     size_z     <= cfg_wdata[4:0];
        vfvc_pkg::CFG_ACTOR_MASK: actor_mask <= cfg_wdata;
        vfvc_pkg::CFG_NB_PRESENT: nb_present <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // neighbor offset per step: center, +z, -z, +y, -y, +x, -x
  always_comb begin
    dx = '0;
    dy = '0;
    dz = '0;
    case (step)
      3'd1: dz = 6'sd1;
      3'd2: dz = -6'sd1;
      3'd3: dy = 6'sd1;
      3'd4: dy = -6'sd1;
      3'd5: dx = 6'sd1;
      3'd6: dx = -6'sd1;
      default: ;
    endcase
  end

  assign nx = $signed({2'b00, ev_x}) + dx;
  assign ny = $signed({2'b00, ev_y}) + dy;
  assign nz = $signed({2'b00, ev_z}) + dz;

  assign x_neg = nx[5];
  assign y_neg = ny[5];
  assign x_hi  = !nx[5] && (nx[4:0] >= sx);
  assign y_hi  = !ny[5] && (ny[4:0] >= sy);
  assign z_in  = !nz[5] && (nz[4:0] < sz);

  always_comb begin
    if (x_neg) begin
      nb_region = vfvc_pkg::REG_BACK;
    end else if (x_hi) begin
      nb_region = vfvc_pkg::REG_FRONT;
    end else if (y_neg) begin
      nb_region = vfvc_pkg::REG_LEFT;
    end else begin
      nb_region = vfvc_pkg::REG_RIGHT;
    end
  end

  assign nb_fc = (nb_region == vfvc_pkg::REG_BACK || nb_region == vfvc_pkg::REG_FRONT)
                 ? ny[4:0] : nx[4:0];
  assign nb_cell_addr = cell_index(nx[4:0], ny[4:0], nz[4:0]);
  assign nb_face_addr = face_index(nb_region, nb_fc, nz[4:0]);

  always_comb begin
    if (!ev_inside || !z_in) begin
      nb_src = vfvc_pkg::SRC_ZERO;
    end else if (!x_neg && !x_hi && !y_neg && !y_hi) begin
      nb_src = vfvc_pkg::SRC_CELL;
    end else if (nb_present[nb_region]) begin
      nb_src = vfvc_pkg::SRC_FACE;
    end else begin
      nb_src = vfvc_pkg::SRC_ZERO;
    end
  end

  // type returned by the read issued in the previous lookup step
  always_comb begin
    case (pend_src)
      vfvc_pkg::SRC_CELL: nb_data = cell_rdata[3:0];
      vfvc_pkg::SRC_FACE: nb_data = face_rdata;
      default:            nb_data = 4'd0;
    endcase
  end

  // classification, with the last neighbor taken from the held read data
  assign out_room  = !m_tvalid || m_tready;
  assign vis_final = vis || (nb_data == 4'd0);
  assign ctype     = ev_inside ? center[3:0] : 4'd0;

  always_comb begin
    spawn = 1'b0;
    if (ctype == 4'd0) begin
      cls = vfvc_pkg::CLS_EMPTY;
    end else if (!vis_final) begin
      cls = vfvc_pkg::CLS_CULLED;
    end else if (!is_actor(ctype, actor_mask)) begin
      cls = vfvc_pkg::CLS_INST;
    end else if (!center[4]) begin
      cls   = vfvc_pkg::CLS_SPAWN;
      spawn = 1'b1;
    end else begin
      cls = vfvc_pkg::CLS_SPAWNED;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vfvc_pkg::ST_CLEAR: begin
        if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) state_next = vfvc_pkg::ST_IDLE;
      end
      vfvc_pkg::ST_IDLE: begin
        if (s_xfer && in_cmd == vfvc_pkg::CMD_EVAL) state_next = vfvc_pkg::ST_ISSUE;
      end
      vfvc_pkg::ST_ISSUE: begin
        if (step == 3'd6) state_next = vfvc_pkg::ST_FINISH;
      end
      vfvc_pkg::ST_FINISH: begin
        if (out_room) state_next = vfvc_pkg::ST_IDLE;
      end
      default: state_next = vfvc_pkg::ST_CLEAR;
    endcase
  end

  // store ports and handshake
  always_comb begin
    s_tready   = 1'b0;
    cell_we    = 1'b0;
    face_we    = 1'b0;
    cell_addr  = nb_cell_addr;
    face_addr  = nb_face_addr;
    cell_wdata = {in_spawned, in_type};
    face_wdata = in_type;
    case (state)
      vfvc_pkg::ST_CLEAR: begin
        cell_addr  = clr_cnt[CELL_AW-1:0];
        face_addr  = clr_cnt[FACE_AW-1:0];
        cell_wdata = '0;
        face_wdata = '0;
        cell_we    = 32'(clr_cnt) < CELL_DEPTH;
        face_we    = 32'(clr_cnt) < FACE_DEPTH;
      end
      vfvc_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        cell_addr = in_inside ? cell_index({1'b0, in_x}, {1'b0, in_y}, {1'b0, in_z}) : '0;
        face_addr = face_ok ? face_index(in_region, in_fc, {1'b0, in_z}) : '0;
        cell_we   = s_xfer && in_cmd == vfvc_pkg::CMD_LOAD_CELL && in_inside;
        face_we   = s_xfer && in_cmd == vfvc_pkg::CMD_LOAD_FACE && face_ok;
      end
      vfvc_pkg::ST_ISSUE: begin
        if (nb_src != vfvc_pkg::SRC_CELL) cell_addr = '0;
        if (nb_src != vfvc_pkg::SRC_FACE) face_addr = '0;
      end
      vfvc_pkg::ST_FINISH: begin
        cell_addr  = ev_inside ? cell_index({1'b0, ev_x}, {1'b0, ev_y}, {1'b0, ev_z}) : '0;
        face_addr  = '0;
        cell_wdata = {1'b1, center[3:0]};
        cell_we    = out_room && spawn;
      end
      default: ;
    endcase
  end

  // hold the last neighbor read while the classification waits
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_addr] <= cell_wdata;
    end else if (state != vfvc_pkg::ST_FINISH) begin
      cell_rdata <= cell_mem[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (face_we) begin
      face_mem[face_addr] <= face_wdata;
    end else if (state != vfvc_pkg::ST_FINISH) begin
      face_rdata <= face_mem[face_addr];
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= vfvc_pkg::ST_CLEAR;
      clr_cnt  <= '0;
      step     <= '0;
      pend_src <= vfvc_pkg::SRC_ZERO;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == vfvc_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == vfvc_pkg::ST_IDLE) step <= '0;
      if (state == vfvc_pkg::ST_ISSUE) begin
        step     <= step + 3'd1;
        pend_src <= nb_src;
      end
      if (state == vfvc_pkg::ST_FINISH && out_room) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // evaluate payload and accumulators
  always_ff @(posedge clk) begin
    if (s_xfer && in_cmd == vfvc_pkg::CMD_EVAL) begin
      ev_x      <= in_x;
      ev_y      <= in_y;
      ev_z      <= in_z;
      ev_inside <= in_inside;
    end
    if (state == vfvc_pkg::ST_ISSUE) begin
      case (step)
        3'd0: ;
        3'd1: center <= (pend_src == vfvc_pkg::SRC_CELL) ? cell_rdata : 5'd0;
        3'd2: vis <= (nb_data == 4'd0) || is_actor(nb_data, actor_mask);
        default: vis <= vis || (nb_data == 4'd0);
      endcase
    end
    if (state == vfvc_pkg::ST_FINISH && out_room) begin
      m_tuser <= cls;
      m_tdata <= {ev_z, ev_y, ev_x, ctype};
    end
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == vfvc_pkg::ST_IDLE && clr_cnt == CLR_W'(CLR_DEPTH - 1) + 1'b1)
    else $error("input ready outside idle or before the clearing sweep ended");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == vfvc_pkg::ST_FINISH)
    else $error("result appeared without a classification");

  a_spawn_write: assert property (@(posedge clk) disable iff (rst)
    (state == vfvc_pkg::ST_FINISH && cell_we) |->
      cell_wdata[4] && is_actor(cell_wdata[3:0], actor_mask) && !center[4])
    else $error("spawned flag written for a non-actor or already spawned cell");

  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && in_cmd == vfvc_pkg::CMD_EVAL) |=> state == vfvc_pkg::ST_ISSUE && step == 3'd0)
    else $error("evaluate transfer did not start the lookup sequence");

  a_issue_len: assert property (@(posedge clk) disable iff (rst)
    (state == vfvc_pkg::ST_FINISH) |-> $past(state) == vfvc_pkg::ST_FINISH ||
      ($past(state) == vfvc_pkg::ST_ISSUE && $past(step) == 3'd6))
    else $error("classification entered before all neighbors were read");
`endif

endmodule

`default_nettype wire
